// ===== hdl/bur_pkg.sv =====
package bur_pkg;

  // Item kinds
  localparam logic [1:0] MODE_BUS_READ  = 2'd0;
  localparam logic [1:0] MODE_BUS_WRITE = 2'd1;
  localparam logic [1:0] MODE_LINK_RX   = 2'd2;
  localparam logic [1:0] MODE_LINK_TAKE = 2'd3;

  // Register numbers with side effects
  localparam logic [3:0] REG_STATUS  = 4'd1;
  localparam logic [3:0] REG_RX_DATA = 4'd2;
  localparam logic [3:0] REG_TX_DATA = 4'd3;
  localparam logic [3:0] REG_DIV_LO  = 4'd4;
  localparam logic [3:0] REG_DIV_MID = 4'd5;
  localparam logic [3:0] REG_DIV_HI  = 4'd6;

  // Status bits merged into reads of the status register
  localparam logic [7:0] ST_TX_FULL  = 8'h08;
  localparam logic [7:0] ST_RX_FULL  = 8'h10;
  localparam logic [7:0] ST_TX_EMPTY = 8'h20;
  localparam logic [7:0] ST_RX_EMPTY = 8'h40;
  localparam logic [7:0] ST_MASK     =
    8'hFF & ~(ST_TX_FULL | ST_RX_FULL | ST_TX_EMPTY | ST_RX_EMPTY);

  localparam logic [7:0] EMPTY_PEEK = 8'hFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture request, sample FIFO heads
    logic exec;  // apply request, register result
  } bur_cmd_t;

endpackage

// ===== hdl/bur_fifo.sv =====
module bur_fifo #(
  parameter int DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       push_i,
  input  logic       pop_i,
  input  logic [7:0] wdata_i,
  output logic [7:0] rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W:0]   sum;
  logic [PTR_W-1:0] waddr;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == FULL_C);
  assign empty_o = (count_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;

  // tail = head + count, wrapped once
  always_comb begin
    sum = {1'b0, head_q} + {1'b0, count_q[PTR_W-1:0]};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    waddr = sum[PTR_W-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_ok) begin
      head_d  = (head_q == LAST) ? '0 : head_q + PTR_W'(1);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bur_datapath.sv =====
module bur_datapath import bur_pkg::*; #(
  parameter int FIFO_DEPTH = 256,
  parameter int REG_COUNT  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bur_cmd_t   cmd_i,
  input  logic [1:0] mode_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] data_byte_i,
  output logic [7:0] read_data_o,
  output logic       link_byte_valid_o,
  output logic [7:0] link_byte_o,
  output logic       dropped_o,
  output logic [23:0] baud_div_o
);

  localparam int RIDX_W = $clog2(REG_COUNT);
  localparam logic [4:0] REG_LIMIT = 5'(REG_COUNT);

  logic [1:0] mode_q;
  logic [3:0] idx_q;
  logic [7:0] data_q;
  logic [7:0] rf_q [REG_COUNT];

  logic [7:0] read_data_q, read_data_d;
  logic [7:0] link_byte_q, link_byte_d;
  logic       link_valid_q, link_valid_d;
  logic       dropped_q, dropped_d;

  logic       idx_ok, rf_we;
  logic [7:0] rf_rd;
  logic       rx_push, rx_pop, tx_push, tx_pop;
  logic [7:0] rx_head, tx_head;
  logic       rx_full, rx_empty, tx_full, tx_empty;
  logic [7:0] status;

  bur_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cmd_i.load),
    .push_i  (rx_push),
    .pop_i   (rx_pop),
    .wdata_i (data_q),
    .rdata_o (rx_head),
    .full_o  (rx_full),
    .empty_o (rx_empty)
  );

  bur_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cmd_i.load),
    .push_i  (tx_push),
    .pop_i   (tx_pop),
    .wdata_i (data_q),
    .rdata_o (tx_head),
    .full_o  (tx_full),
    .empty_o (tx_empty)
  );

  // Hold the request until it is applied
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      idx_q  <= reg_index_i;
      data_q <= data_byte_i;
    end
  end

  assign idx_ok = ({1'b0, idx_q} < REG_LIMIT);
  assign rf_rd  = idx_ok ? rf_q[idx_q[RIDX_W-1:0]] : 8'h00;
  assign status = (tx_full  ? ST_TX_FULL  : 8'h00) | (rx_full  ? ST_RX_FULL  : 8'h00) |
                  (tx_empty ? ST_TX_EMPTY : 8'h00) | (rx_empty ? ST_RX_EMPTY : 8'h00);

  always_comb begin
    read_data_d  = 8'h00;
    link_valid_d = 1'b0;
    link_byte_d  = 8'h00;
    dropped_d    = 1'b0;
    rf_we        = 1'b0;
    rx_push      = 1'b0;
    rx_pop       = 1'b0;
    tx_push      = 1'b0;
    tx_pop       = 1'b0;
    if (cmd_i.exec) begin
      unique case (mode_q)
        MODE_BUS_READ: begin
          if (idx_q == REG_STATUS) begin
            read_data_d = status | (rf_q[REG_STATUS[RIDX_W-1:0]] & ST_MASK);
          end else if (idx_q == REG_RX_DATA) begin
            read_data_d = rx_empty ? EMPTY_PEEK : rx_head;
          end else begin
            read_data_d = rf_rd;
          end
        end
        MODE_BUS_WRITE: begin
          if (idx_ok) begin
            rf_we = 1'b1;
            if (idx_q == REG_RX_DATA) begin
              rx_pop = 1'b1;
            end else if (idx_q == REG_TX_DATA) begin
              tx_push   = 1'b1;
              dropped_d = tx_full;
            end
          end
        end
        MODE_LINK_RX: begin
          rx_push   = 1'b1;
          dropped_d = rx_full;
        end
        MODE_LINK_TAKE: begin
          if (!tx_empty) begin
            link_valid_d = 1'b1;
            link_byte_d  = tx_head;
            tx_pop       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= 8'h00;
      end
    end else if (rf_we) begin
      rf_q[idx_q[RIDX_W-1:0]] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      read_data_q  <= read_data_d;
      link_valid_q <= link_valid_d;
      link_byte_q  <= link_byte_d;
      dropped_q    <= dropped_d;
    end
  end

  assign read_data_o       = read_data_q;
  assign link_byte_valid_o = link_valid_q;
  assign link_byte_o       = link_byte_q;
  assign dropped_o         = dropped_q;
  assign baud_div_o        = {rf_q[REG_DIV_HI[RIDX_W-1:0]], rf_q[REG_DIV_MID[RIDX_W-1:0]],
                              rf_q[REG_DIV_LO[RIDX_W-1:0]]};

endmodule

// ===== hdl/bur_ctrl.sv =====
module bur_ctrl import bur_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output bur_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q == S_EXEC);
  assign done_o = done_q;

endmodule

// ===== hdl/buffered_uart_register_block.sv =====
// Channel   Handshake                    Payload
// request   start_i high, busy_o low     mode_i, reg_index_i, data_byte_i
// result    done_o high for one cycle    read_data_o, link_byte_valid_o, link_byte_o,
//                                        dropped_o, baud_div_o
//
// Accepting a request captures it and reads both FIFO heads; the exec state then
// applies it and registers the result, shown with done_o. No request is taken while
// busy_o is high, and it is low again while done_o is high.
// Reset is asynchronous and clears the register file and the FIFO pointers and counts;
// FIFO storage is not cleared, since the head of an empty FIFO is never used.
// The receiver cannot stall, so a result is never held back.
module buffered_uart_register_block import bur_pkg::*; #(
  parameter int FIFO_DEPTH = 256,
  parameter int REG_COUNT  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  reg_index_i,
  input  logic [7:0]  data_byte_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        link_byte_valid_o,
  output logic [7:0]  link_byte_o,
  output logic        dropped_o,
  output logic [23:0] baud_div_o
);

  bur_cmd_t cmd;

  // Sequence capture and apply for each request
  bur_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Hold register file, both FIFOs and the result registers
  bur_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .REG_COUNT  (REG_COUNT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .mode_i            (mode_i),
    .reg_index_i       (reg_index_i),
    .data_byte_i       (data_byte_i),
    .read_data_o       (read_data_o),
    .link_byte_valid_o (link_byte_valid_o),
    .link_byte_o       (link_byte_o),
    .dropped_o         (dropped_o),
    .baud_div_o        (baud_div_o)
  );

endmodule

// ===== hdl/bur_checker.sv =====
module bur_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       link_byte_valid_o,
  input logic [7:0] link_byte_o,
  input logic       dropped_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("accepted request gave no result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && !$past(done_o))
    else $error("result strobe while busy or repeated");

  a_link_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !link_byte_valid_o |-> link_byte_o == 8'h00)
    else $error("link byte not zero without valid");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(dropped_o && link_byte_valid_o))
    else $error("drop and take in one result");

endmodule

bind buffered_uart_register_block bur_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .link_byte_valid_o (link_byte_valid_o),
  .link_byte_o       (link_byte_o),
  .dropped_o         (dropped_o)
);
